### sv/min_coin_change_dp_macros.svh
// ---------------------------------------------------------------------------
// min_coin_change_dp assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef MIN_COIN_CHANGE_DP_MACROS_SVH
`define MIN_COIN_CHANGE_DP_MACROS_SVH

// same-cycle implication
`define MCC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mcc_pkg.sv
// ---------------------------------------------------------------------------
// mcc_pkg
// Widths, codes and types shared by the minimum coin change blocks
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcc_pkg;

  localparam int MAX_AMOUNT = 1023;
  localparam int MAX_TYPES  = 6;
  localparam int AMT_W      = 10;
  localparam int COIN_W     = 10;
  localparam int NUM_W      = 3;
  localparam int IDX_W      = 3;
  localparam int CNT_W      = AMT_W + 1;
  localparam int DEPTH      = MAX_AMOUNT + 1;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int ENTRY_W    = IDX_W + CNT_W;

  // count code for values that cannot be formed
  localparam logic [CNT_W-1:0] INF_COUNT = {CNT_W{1'b1}};

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_COIN_COUNT,
    REG_COIN_0,
    REG_COIN_1,
    REG_COIN_2,
    REG_COIN_3,
    REG_COIN_4,
    REG_COIN_5
  } cfg_reg_t;

  typedef logic [MAX_TYPES-1:0][COIN_W-1:0] coin_arr_t;

  // one per-denomination result
  typedef struct packed {
    logic              last_result;
    logic              reachable;
    logic [AMT_W-1:0]  total_coins;
    logic [AMT_W-1:0]  used_count;
    logic [COIN_W-1:0] coin_value;
    logic [IDX_W-1:0]  coin_index;
  } mcc_result_t;

endpackage

### sv/mcc_core.sv
// ---------------------------------------------------------------------------
// mcc_core
// Table fill, traceback and per-coin result sequencing over one table memory
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "min_coin_change_dp_macros.svh"

module mcc_core
  import mcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              idle,
  input  logic [AMT_W-1:0]  amount,
  input  logic [NUM_W-1:0]  coin_count,
  input  coin_arr_t         coins,
  output logic              res_valid,
  input  logic              res_ready,
  output mcc_result_t       res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_FILL,
    ST_TRD,
    ST_TEX,
    ST_EMIT
  } state_t;

  state_t                         state;
  logic [AMT_W-1:0]               amt;
  logic [NUM_W-1:0]               n;
  logic [AMT_W-1:0]               i;
  logic [NUM_W-1:0]               j;
  logic [CNT_W-1:0]               best;
  logic [IDX_W-1:0]               pick;
  logic                           rd_vld;
  logic [IDX_W-1:0]               rd_j;
  logic [AMT_W-1:0]               v;
  logic                           first;
  logic                           reach;
  logic [AMT_W-1:0]               total;
  logic [IDX_W-1:0]               emit_j;
  logic [MAX_TYPES-1:0][AMT_W-1:0] used;

  // table memory: {chosen coin, min count}
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;

  logic [NUM_W-1:0]   n_sat;
  logic [COIN_W-1:0]  cur_coin;
  logic               use_j;
  logic [CNT_W-1:0]   rd_cnt;
  logic [IDX_W-1:0]   rd_pick;
  logic [CNT_W-1:0]   cand;
  logic               upd;
  logic [CNT_W-1:0]   best_cur;
  logic [IDX_W-1:0]   pick_cur;
  logic               tr_reach;
  logic [COIN_W-1:0]  tr_coin;
  logic               tr_stop;
  logic [AMT_W-1:0]   v_next;

  // saturate the number of denominations
  assign n_sat = (coin_count > NUM_W'(MAX_TYPES)) ? NUM_W'(MAX_TYPES) : coin_count;

  // coin under test in the fill loop
  assign cur_coin = (j < NUM_W'(MAX_TYPES)) ? coins[j] : '0;
  assign use_j    = (state == ST_FILL) && (j < n) && (cur_coin != '0) &&
                    (cur_coin <= i);

  // compare of the entry read in the previous cycle
  assign rd_cnt   = rdata[CNT_W-1:0];
  assign rd_pick  = rdata[ENTRY_W-1:CNT_W];
  assign cand     = rd_cnt + CNT_W'(1);
  assign upd      = rd_vld && (rd_cnt != INF_COUNT) && (cand < best);
  assign best_cur = upd ? cand : best;
  assign pick_cur = upd ? rd_j : pick;

  // traceback step
  assign tr_reach = first ? (rd_cnt != INF_COUNT) : reach;
  assign tr_coin  = (rd_pick < IDX_W'(MAX_TYPES)) ? coins[rd_pick] : '0;
  assign tr_stop  = (tr_coin == '0) || (tr_coin > v);
  assign v_next   = v - tr_coin;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = i;
    mem_wdata = {pick_cur, best_cur};
    mem_raddr = v;
    unique case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = '0;
      end
      ST_FILL: begin
        mem_we    = (j == n);
        mem_raddr = i - cur_coin;
      end
      default: begin
      end
    endcase
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd_vld <= 1'b0;
      j      <= '0;
      emit_j <= '0;
      first  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            amt    <= amount;
            n      <= n_sat;
            i      <= AMT_W'(1);
            j      <= '0;
            best   <= INF_COUNT;
            pick   <= '0;
            rd_vld <= 1'b0;
            used   <= '0;
            emit_j <= '0;
            if (n_sat != '0) begin
              state <= ST_INIT;
            end
          end
        end
        ST_INIT: begin
          v     <= amt;
          first <= 1'b1;
          state <= (amt == '0) ? ST_TRD : ST_FILL;
        end
        ST_FILL: begin
          if (j == n) begin
            best   <= INF_COUNT;
            pick   <= '0;
            rd_vld <= 1'b0;
            j      <= '0;
            if (i == amt) begin
              state <= ST_TRD;
            end else begin
              i <= i + AMT_W'(1);
            end
          end else begin
            best   <= best_cur;
            pick   <= pick_cur;
            rd_vld <= use_j;
            rd_j   <= j;
            j      <= j + NUM_W'(1);
          end
        end
        ST_TRD: begin
          state <= ST_TEX;
        end
        ST_TEX: begin
          first <= 1'b0;
          if (first) begin
            reach <= tr_reach;
            total <= tr_reach ? rd_cnt[AMT_W-1:0] : '0;
          end
          if (!tr_reach || (v == '0)) begin
            state <= ST_EMIT;
          end else begin
            if (rd_pick < IDX_W'(MAX_TYPES)) begin
              used[rd_pick] <= used[rd_pick] + AMT_W'(1);
            end
            if (tr_stop || (v_next == '0)) begin
              state <= ST_EMIT;
            end else begin
              v     <= v_next;
              state <= ST_TRD;
            end
          end
        end
        ST_EMIT: begin
          if (res_ready) begin
            if (emit_j == n - NUM_W'(1)) begin
              state <= ST_IDLE;
            end else begin
              emit_j <= emit_j + IDX_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_EMIT);

  // per-coin result
  always_comb begin
    res             = '0;
    res.coin_index  = emit_j;
    res.coin_value  = (emit_j < IDX_W'(MAX_TYPES)) ? coins[emit_j] : '0;
    res.used_count  = (emit_j < IDX_W'(MAX_TYPES)) ? used[emit_j] : '0;
    res.total_coins = total;
    res.reachable   = reach;
    res.last_result = (emit_j == n - NUM_W'(1));
  end

  // fill only reads entries below the one being built
  `MCC_ASSERT_IMP(a_fill_reads_older, use_j, mem_raddr < i, "fill read at or above value")
  // writes stay within the current amount
  `MCC_ASSERT_IMP(a_write_in_range, mem_we, mem_waddr <= amt, "table write beyond amount")
  // every value visited after a reachable amount is itself reachable
  `MCC_ASSERT_IMP(a_trace_reachable, (state == ST_TEX) && !first && reach,
    rd_cnt != INF_COUNT, "traceback reached an unreachable value")
  // an accepted amount with coins in use starts a run
  `MCC_ASSERT_NXT(a_start_run, (state == ST_IDLE) && start && (n_sat != '0),
    state == ST_INIT, "accepted amount did not start a run")

endmodule

### sv/min_coin_change_dp.sv
// ---------------------------------------------------------------------------
// min_coin_change_dp
// Minimum coin change: fills a table of least coin counts, traces the
// choice back and reports one result per denomination in use
// ---------------------------------------------------------------------------
// channel   direction  handshake               payload
// s_axis    in         s_axis_tvalid/tready    amount
// m_axis    out        m_axis_tvalid/tready    per-coin result, tlast on final
// cfg       in         cfg_valid/cfg_ready     register index and data
//
// one amount runs the table fill, then one traceback step per coin used (at least
// one), then one result per denomination in use
// the table read port sets the fill pace; results leave one per cycle when unstalled
// reset is synchronous; the table needs no clearing after reset
// a new amount is accepted once the last result is in the output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_coin_change_dp
  import mcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // amount[9:0], zero fill
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // coin_index[2:0], coin_value[12:3],
                                      // used_count[22:13], total_coins[32:23],
                                      // reachable[33], zero fill
  output logic        m_axis_tlast    // last_result
);

  logic [NUM_W-1:0] coin_count;
  coin_arr_t        coins;
  logic             core_idle;
  logic             res_valid;
  logic             res_ready;
  mcc_result_t      res;

  // configuration registers
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      coin_count <= NUM_W'(1);
      for (int k = 0; k < MAX_TYPES; k++) begin
        coins[k] <= COIN_W'(1);
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COIN_COUNT: coin_count <= cfg_data[NUM_W-1:0];
        REG_COIN_0:     coins[0]   <= cfg_data;
        REG_COIN_1:     coins[1]   <= cfg_data;
        REG_COIN_2:     coins[2]   <= cfg_data;
        REG_COIN_3:     coins[3]   <= cfg_data;
        REG_COIN_4:     coins[4]   <= cfg_data;
        REG_COIN_5:     coins[5]   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = core_idle && !rst;

  mcc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .start      (s_axis_tvalid),
    .idle       (core_idle),
    .amount     (s_axis_tdata[AMT_W-1:0]),
    .coin_count (coin_count),
    .coins      (coins),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_axis_tdata <= {6'b0, res.reachable, res.total_coins, res.used_count,
                       res.coin_value, res.coin_index};
      m_axis_tlast <= res.last_result;
    end
  end

endmodule

### tb/sv/min_coin_change_dp_tb.sv
// ---------------------------------------------------------------------------
// min_coin_change_dp_tb
// Drives amounts into the coin change block under several denomination sets,
// predicts the per-coin breakdown with a local dynamic-programming model and
// checks every result transfer in order, with random idling on both streams
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_coin_change_dp_tb
  import mcc_pkg::*;
();

  localparam int          CLK_PERIOD = 8;
  localparam int          UNREACH    = 1 << 20;
  localparam logic [2:0]  REG_NONE   = 3'd7;   // index past the register file
  localparam int          HOLD_AT    = 60;     // result that starts the long hold-off
  localparam int          HOLD_LEN   = 400;
  localparam int          MAX_PRINTS = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  // local copy of the configuration
  logic [2:0]        coin_cnt = 3'd1;
  logic [COIN_W-1:0] coin_val [MAX_TYPES] = '{default: 10'd1};

  // dp scratch tables for the predictor
  int best_cnt [DEPTH];
  int best_pick [DEPTH];

  logic [AMT_W-1:0] amount_q [$];
  mcc_result_t      change_q [$];

  int err_cnt = 0;
  int result_cnt = 0;

  // driver state
  int s_gap = 0;
  bit s_burst = 1'b0;

  // receiver state
  int m_gap = 0;
  int hold_cnt = 0;
  bit m_burst = 1'b0;

  min_coin_change_dp dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // min coin breakdown for one amount under the current coin set
  function automatic void predict_change(input logic [AMT_W-1:0] amt);
    int n;
    int used [MAX_TYPES];
    int best;
    int pick;
    int c;
    int v;
    int k;
    int total;
    bit reach;
    mcc_result_t r;
    n = (coin_cnt > MAX_TYPES) ? MAX_TYPES : int'(coin_cnt);
    if (n == 0) return;
    foreach (used[j]) used[j] = 0;
    best_cnt[0] = 0;
    best_pick[0] = 0;
    for (int i = 1; i <= int'(amt); i++) begin
      best = UNREACH;
      pick = 0;
      for (int j = 0; j < n; j++) begin
        c = int'(coin_val[j]);
        if (c != 0 && c <= i) begin
          if (best_cnt[i - c] != UNREACH && best_cnt[i - c] + 1 < best) begin
            best = best_cnt[i - c] + 1;
            pick = j;
          end
        end
      end
      best_cnt[i] = best;
      best_pick[i] = pick;
    end
    reach = (best_cnt[amt] != UNREACH);
    total = reach ? best_cnt[amt] : 0;
    // walk the chosen coins back down to zero
    if (reach) begin
      v = int'(amt);
      while (v > 0) begin
        k = best_pick[v] % MAX_TYPES;
        c = int'(coin_val[k]);
        used[k]++;
        if (c == 0 || c > v) break;
        v -= c;
      end
    end
    for (int j = 0; j < n; j++) begin
      r.coin_index  = IDX_W'(j);
      r.coin_value  = coin_val[j];
      r.used_count  = AMT_W'(used[j]);
      r.total_coins = AMT_W'(total);
      r.reachable   = reach;
      r.last_result = (j == n - 1);
      change_q.push_back(r);
    end
  endfunction

  task automatic check_field(input string nm, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      err_cnt++;
      if (err_cnt <= MAX_PRINTS)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, nm, want, got);
    end
  endtask

  // amount driver, fed from amount_q
  always @(posedge clk) begin : amount_driver
    logic [AMT_W-1:0] next_amt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_gap         <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predict_change(s_axis_tdata[AMT_W-1:0]);
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the offered item
      end else if (s_gap > 0) begin
        s_gap         <= s_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (amount_q.size() > 0) begin
        next_amt = amount_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(16 - AMT_W){1'b0}}, next_amt};
        if ($urandom_range(0, 11) == 0) s_burst = ~s_burst;
        s_gap <= s_burst ? 0 : $urandom_range(0, 13);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result monitor and ready control
  always @(posedge clk) begin : result_monitor
    mcc_result_t want;
    int g;
    int h;
    if (rst) begin
      m_axis_tready <= 1'b0;
      m_gap         <= 0;
      hold_cnt      <= 0;
    end else begin
      g = m_gap;
      h = hold_cnt;
      if (m_axis_tvalid && m_axis_tready) begin
        if (change_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_PRINTS)
            $display("%0t: unexpected result transfer: expected none, actual %h",
                     $time, m_axis_tdata);
        end else begin
          want = change_q.pop_front();
          check_field("coin_index",  32'(want.coin_index),  32'(m_axis_tdata[2:0]));
          check_field("coin_value",  32'(want.coin_value),  32'(m_axis_tdata[12:3]));
          check_field("used_count",  32'(want.used_count),  32'(m_axis_tdata[22:13]));
          check_field("total_coins", 32'(want.total_coins), 32'(m_axis_tdata[32:23]));
          check_field("reachable",   32'(want.reachable),   32'(m_axis_tdata[33]));
          check_field("last_result", 32'(want.last_result), 32'(m_axis_tlast));
        end
        result_cnt++;
        if ($urandom_range(0, 11) == 0) m_burst = ~m_burst;
        g = m_burst ? 0 : $urandom_range(0, 13);
        // one long stall so the input side backs up
        if (result_cnt == HOLD_AT) h = HOLD_LEN;
      end
      if (h > 0) begin
        h--;
        m_axis_tready <= 1'b0;
      end else if (g > 0) begin
        g--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
      m_gap    <= g;
      hold_cnt <= h;
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [9:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_COIN_COUNT)
      coin_cnt = data[2:0];
    else if (idx <= REG_COIN_5)
      coin_val[idx - REG_COIN_0] = data;
  endtask

  task automatic load_coins(input logic [2:0] cnt, input coin_arr_t vals);
    cfg_write(REG_COIN_COUNT, {7'd0, cnt});
    for (int j = 0; j < MAX_TYPES; j++)
      cfg_write(3'(REG_COIN_0 + j), vals[j]);
  endtask

  function automatic coin_arr_t coin_set(input int c0, c1, c2, c3, c4, c5);
    coin_arr_t v;
    v[0] = COIN_W'(c0);
    v[1] = COIN_W'(c1);
    v[2] = COIN_W'(c2);
    v[3] = COIN_W'(c3);
    v[4] = COIN_W'(c4);
    v[5] = COIN_W'(c5);
    return v;
  endfunction

  // wait until every amount is taken and every result is in
  task automatic drain();
    while (amount_q.size() != 0 || s_axis_tvalid || change_q.size() != 0)
      @(posedge clk);
    // with no denominations in use an amount leaves no result behind
    repeat ((coin_cnt == 0) ? 2100 : 32) @(posedge clk);
  endtask

  function automatic logic [AMT_W-1:0] rand_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return AMT_W'(MAX_AMOUNT);
    if (r < 18) return AMT_W'($urandom_range(0, MAX_AMOUNT));
    return AMT_W'($urandom_range(0, 120));
  endfunction

  function automatic logic [COIN_W-1:0] rand_coin();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r < 3) return COIN_W'($urandom_range(1, 1023));
    return COIN_W'($urandom_range(1, 40));
  endfunction

  // stimulus
  initial begin : stimulus
    coin_arr_t cs;
    logic [2:0] cnt;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: a single coin of one
    amount_q = {amount_q, 10'd0, 10'd1, 10'd1023};
    drain();

    // common coin set, all six in use
    load_coins(3'd6, coin_set(1, 5, 10, 25, 50, 100));
    amount_q = {amount_q, 10'd0, 10'd3, 10'd30, 10'd99, 10'd641, 10'd1023};
    drain();

    // zero-valued coin, duplicates, an unreachable amount
    load_coins(3'd3, coin_set(0, 7, 7, 1, 1, 1));
    amount_q = {amount_q, 10'd14, 10'd13, 10'd0, 10'd700};
    drain();

    // count saturates, coins bigger than most amounts, stray index write
    load_coins(3'd7, coin_set(1023, 512, 341, 2, 4, 6));
    cfg_write(REG_NONE, 10'h3ff);
    amount_q = {amount_q, 10'd1023, 10'd1, 10'd511, 10'd682, 10'd5};
    drain();

    // no denominations in use
    cfg_write(REG_COIN_COUNT, 10'd0);
    amount_q = {amount_q, 10'd5, 10'd300, 10'd0};
    drain();

    // random coin sets with random amounts
    for (int p = 0; p < 5; p++) begin
      cnt = ($urandom_range(0, 9) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
      for (int j = 0; j < MAX_TYPES; j++) cs[j] = rand_coin();
      load_coins(cnt, cs);
      for (int i = 0; i < 16; i++) amount_q.push_back(rand_amount());
      drain();
    end

    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
